// ===== design/usb_boot_keyboard_to_ps2_macros.svh =====
// Assertion macros used by the keyboard translator checker.
`ifndef USB_BOOT_KEYBOARD_TO_PS2_MACROS_SVH
`define USB_BOOT_KEYBOARD_TO_PS2_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UBK_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UBK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ubk_pkg.sv =====
// Types, constants and the scan-code table of the keyboard translator.
package ubk_pkg;

    localparam int KEY_SLOTS = 6;
    localparam int SLOT_W    = $clog2(KEY_SLOTS);
    localparam int POS_W     = $clog2(KEY_SLOTS + 1);
    localparam int TABLE_LEN = 101;
    localparam int ROM_IDX_W = $clog2(TABLE_LEN);

    localparam logic [7:0]  LSHIFT_BIT = 8'h02;
    localparam logic [7:0]  RSHIFT_BIT = 8'h20;
    localparam logic [15:0] SHIFT_CODE = 16'h002A;

    // Usage 100 has no code and reads as zero.
    localparam logic [15:0] SCAN_ROM [TABLE_LEN] = '{
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h001e, 16'h0030, 16'h002e, 16'h0020,
        16'h0012, 16'h0021, 16'h0022, 16'h0023, 16'h0017, 16'h0024, 16'h0025, 16'h0026,
        16'h0032, 16'h0031, 16'h0018, 16'h0019, 16'h0010, 16'h0013, 16'h001f, 16'h0014,
        16'h0016, 16'h002f, 16'h0011, 16'h002d, 16'h0015, 16'h002c, 16'h0002, 16'h0003,
        16'h0004, 16'h0005, 16'h0006, 16'h0007, 16'h0008, 16'h0009, 16'h000a, 16'h000b,
        16'h001c, 16'h0001, 16'h000e, 16'h000f, 16'h0039, 16'h000c, 16'h000d, 16'h001a,
        16'h001b, 16'h002b, 16'h0000, 16'h0027, 16'h0028, 16'h0029, 16'h0033, 16'h0034,
        16'h0035, 16'h003a, 16'h003b, 16'h003c, 16'h003d, 16'h003e, 16'h003f, 16'h0040,
        16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0057, 16'h0058, 16'he037, 16'h0046,
        16'he145, 16'he052, 16'he047, 16'he049, 16'he053, 16'he04f, 16'he051, 16'he04d,
        16'he04b, 16'he050, 16'he048, 16'h0045, 16'he035, 16'h0037, 16'h004a, 16'h004e,
        16'he01c, 16'h004f, 16'h0050, 16'h0051, 16'h004b, 16'h004c, 16'h004d, 16'h0047,
        16'h0048, 16'h0049, 16'h0052, 16'h0053, 16'h0000
    };

    // Usages past the end of the table map to code zero.
    function automatic logic [15:0] scan_lookup(input logic [7:0] usage);
        if (usage >= 8'(TABLE_LEN)) begin
            return 16'h0000;
        end
        return SCAN_ROM[usage[ROM_IDX_W-1:0]];
    endfunction

    typedef struct packed {
        logic [7:0] modifier_bits;
        logic [7:0] key_0;
        logic [7:0] key_1;
        logic [7:0] key_2;
        logic [7:0] key_3;
        logic [7:0] key_4;
        logic [7:0] key_5;
    } t_in;

    typedef struct packed {
        logic [15:0] scan_code;
        logic        is_press;
        logic        last_of_run;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_SHIFT,
        ST_PRESS,
        ST_RELEASE,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic match_step;
        logic emit_shift;
        logic emit_press;
        logic emit_release;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic match_done;
        logic shift_change;
        logic any_pend;
        logic more_after;
        logic out_free;
    } t_sts;

endpackage

// ===== design/usb_boot_keyboard_to_ps2.sv =====
// Top level of the USB boot-keyboard report to PS/2 set-1 scan-code translator.
//
// Each input beat is one boot-keyboard report (modifier byte plus six key usages); the
// block answers with zero to thirteen output beats of PS/2 set-1 events. When the
// combined shift state (bit 1 or bit 5 of the modifier byte) changes, a 0x2A make or
// break comes first. Then every key that was not held in the previous report gets a
// make beat and a break beat with the same code from a 101-entry table; usages past
// the table give code zero. Keys that leave the report give nothing, nor do the other
// modifier bits. The last beat of a report carries last_of_run. The held-key list is
// kept compacted, kept keys first in their old order, then new keys in slot order.
// One report at a time: the input stalls from acceptance until its events are all
// loaded into the output register. Each held key is compared against all six slots
// at once; the sequencer steps through one held entry per cycle while matching, then
// one output beat per cycle while the output is not stalled, and the single output
// register lets the next report be accepted while the final beat still waits
// downstream.
module usb_boot_keyboard_to_ps2
    import ubk_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_busy;

    // Sequence the phases of one report.
    ubk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy)
    );

    // Hold the key lists and drive the output register.
    ubk_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // Stall new reports while one is in flight.
    assign o_in_stall = w_busy;

endmodule

// ===== design/ubk_ctrl.sv =====
// Sequencer of the keyboard translator: walks match, shift, press and release phases.
module ubk_ctrl
    import ubk_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MATCH;
                end
            end
            ST_MATCH: begin
                if (i_sts.match_done) begin
                    n_state = ST_SHIFT;
                end else begin
                    o_cmd.match_step = 1'b1;
                end
            end
            ST_SHIFT: begin
                // Stay until the shift beat is out, then go on to new keys, if any, or commit.
                if (!i_sts.shift_change) begin
                    n_state = i_sts.any_pend ? ST_PRESS : ST_COMMIT;
                end else if (i_sts.out_free) begin
                    o_cmd.emit_shift = 1'b1;
                end
            end
            ST_PRESS: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_press = 1'b1;
                    n_state          = ST_RELEASE;
                end
            end
            ST_RELEASE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_release = 1'b1;
                    n_state            = i_sts.more_after ? ST_PRESS : ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ===== design/ubk_dp.sv =====
// Datapath of the keyboard translator: key lists, shift flag, table lookup and output register.
module ubk_dp
    import ubk_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_in_data,
    input  logic i_out_stall,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output logic o_out_valid,
    output t_out o_out_data
);

    logic [7:0]       r_slots [KEY_SLOTS];
    logic [7:0]       r_held  [KEY_SLOTS];
    logic [7:0]       r_next  [KEY_SLOTS];
    logic [7:0]       r_mods;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_hidx;
    logic             r_shift_held;
    logic             r_out_valid;
    t_out             r_out_data;

    logic [7:0]          w_in_keys [KEY_SLOTS];
    logic [7:0]          w_hkey;
    logic [KEY_SLOTS-1:0] w_hit;
    logic [KEY_SLOTS-1:0] w_pend;
    logic [KEY_SLOTS-1:0] w_pend_rest;
    logic [SLOT_W-1:0]   w_hit_idx;
    logic [SLOT_W-1:0]   w_low_idx;
    logic [7:0]          w_low_key;
    logic [15:0]         w_low_code;
    logic                w_shift;
    logic                w_out_free;
    logic                w_emit;

    assign w_in_keys[0] = i_in_data.key_0;
    assign w_in_keys[1] = i_in_data.key_1;
    assign w_in_keys[2] = i_in_data.key_2;
    assign w_in_keys[3] = i_in_data.key_3;
    assign w_in_keys[4] = i_in_data.key_4;
    assign w_in_keys[5] = i_in_data.key_5;

    // Held entry under scan; past the end reads as empty, which ends the scan.
    assign w_hkey = (r_hidx < POS_W'(KEY_SLOTS)) ? r_held[r_hidx[SLOT_W-1:0]] : 8'h00;

    always_comb begin
        w_hit_idx = '0;
        w_low_idx = '0;
        for (int j = KEY_SLOTS - 1; j >= 0; j--) begin
            w_hit[j]  = (r_slots[j] == w_hkey);
            w_pend[j] = (r_slots[j] != 8'h00);
            if (w_hit[j]) begin
                w_hit_idx = SLOT_W'(j);
            end
            if (w_pend[j]) begin
                w_low_idx = SLOT_W'(j);
            end
        end
    end

    assign w_pend_rest = w_pend & (w_pend - 1'b1);
    assign w_low_key   = r_slots[w_low_idx];
    assign w_low_code  = scan_lookup(w_low_key);
    assign w_shift     = |(r_mods & (LSHIFT_BIT | RSHIFT_BIT));
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_emit      = i_cmd.emit_shift || i_cmd.emit_press || i_cmd.emit_release;

    assign o_sts.match_done   = (w_hkey == 8'h00);
    assign o_sts.shift_change = (w_shift != r_shift_held);
    assign o_sts.any_pend     = |w_pend;
    assign o_sts.more_after   = |w_pend_rest;
    assign o_sts.out_free     = w_out_free;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= '{default: 8'h00};
            r_shift_held <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pos        <= '0;
            r_hidx       <= '0;
        end else begin
            if (i_cmd.load) begin
                r_pos  <= '0;
                r_hidx <= '0;
            end
            if (i_cmd.match_step) begin
                r_hidx <= r_hidx + 1'b1;
                if (|w_hit && r_pos < POS_W'(KEY_SLOTS)) begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            if (i_cmd.emit_press && r_pos < POS_W'(KEY_SLOTS)) begin
                r_pos <= r_pos + 1'b1;
            end
            if (i_cmd.emit_shift) begin
                r_shift_held <= w_shift;
            end
            if (i_cmd.commit) begin
                r_held <= r_next;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_slots <= w_in_keys;
            r_mods  <= i_in_data.modifier_bits;
            r_next  <= '{default: 8'h00};
        end
        if (i_cmd.match_step && |w_hit) begin
            r_slots[w_hit_idx] <= 8'h00;
            if (r_pos < POS_W'(KEY_SLOTS)) begin
                r_next[r_pos[SLOT_W-1:0]] <= w_hkey;
            end
        end
        if (i_cmd.emit_shift) begin
            r_out_data.scan_code   <= SHIFT_CODE;
            r_out_data.is_press    <= w_shift;
            r_out_data.last_of_run <= !(|w_pend);
        end
        if (i_cmd.emit_press) begin
            r_out_data.scan_code   <= w_low_code;
            r_out_data.is_press    <= 1'b1;
            r_out_data.last_of_run <= 1'b0;
            if (r_pos < POS_W'(KEY_SLOTS)) begin
                r_next[r_pos[SLOT_W-1:0]] <= w_low_key;
            end
        end
        if (i_cmd.emit_release) begin
            r_out_data.scan_code   <= w_low_code;
            r_out_data.is_press    <= 1'b0;
            r_out_data.last_of_run <= !(|w_pend_rest);
            r_slots[w_low_idx]     <= 8'h00;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== design/ubk_checker.sv =====
// Port-level assertions for the keyboard translator, bound to its top level.
`include "usb_boot_keyboard_to_ps2_macros.svh"

module ubk_checker
    import ubk_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    // A stalled output beat holds.
    `UBK_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled output beat changed")

    // An accepted report keeps the input stalled in the next cycle.
    `UBK_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input not stalled after accepted report")

    // Only a shift make can end a run on a press.
    `UBK_ASSERT_IMPL(a_last_press_is_shift, i_clk, i_rst_n, o_out_valid && o_out_data.is_press && o_out_data.last_of_run, o_out_data.scan_code == SHIFT_CODE, "key press marked last of run")

    // A key make is followed at once by its break.
    `UBK_ASSERT_NEXT(a_break_follows_make, i_clk, i_rst_n, o_out_valid && !i_out_stall && o_out_data.is_press && (o_out_data.scan_code != SHIFT_CODE), o_out_valid && !o_out_data.is_press && (o_out_data.scan_code == $past(o_out_data.scan_code)), "key make not followed by matching break")

endmodule

bind usb_boot_keyboard_to_ps2 ubk_checker u_ubk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== sim/usb_boot_keyboard_to_ps2_tb.sv =====
// Self-checking testbench for the USB boot-keyboard report to PS/2 set-1 translator.
import ubk_pkg::*;

// Tracks held keys and shift state, and queues the PS/2 beats each report should cause.
class ps2_event_scoreboard;
    logic [7:0]  down_keys [KEY_SLOTS];
    bit          shift_latched;
    t_out        pending_events [$];
    logic [15:0] set1_codes [TABLE_LEN];
    int          errors;
    int          reports;
    int          beats_checked;
    int          shift_edges;
    int          extended_presses;
    int          longest_run;

    function new();
        foreach (down_keys[i]) down_keys[i] = 8'h00;
        shift_latched    = 1'b0;
        errors           = 0;
        reports          = 0;
        beats_checked    = 0;
        shift_edges      = 0;
        extended_presses = 0;
        longest_run      = 0;
        set1_codes = '{
            16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h001e, 16'h0030, 16'h002e, 16'h0020,
            16'h0012, 16'h0021, 16'h0022, 16'h0023, 16'h0017, 16'h0024, 16'h0025, 16'h0026,
            16'h0032, 16'h0031, 16'h0018, 16'h0019, 16'h0010, 16'h0013, 16'h001f, 16'h0014,
            16'h0016, 16'h002f, 16'h0011, 16'h002d, 16'h0015, 16'h002c, 16'h0002, 16'h0003,
            16'h0004, 16'h0005, 16'h0006, 16'h0007, 16'h0008, 16'h0009, 16'h000a, 16'h000b,
            16'h001c, 16'h0001, 16'h000e, 16'h000f, 16'h0039, 16'h000c, 16'h000d, 16'h001a,
            16'h001b, 16'h002b, 16'h0000, 16'h0027, 16'h0028, 16'h0029, 16'h0033, 16'h0034,
            16'h0035, 16'h003a, 16'h003b, 16'h003c, 16'h003d, 16'h003e, 16'h003f, 16'h0040,
            16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0057, 16'h0058, 16'he037, 16'h0046,
            16'he145, 16'he052, 16'he047, 16'he049, 16'he053, 16'he04f, 16'he051, 16'he04d,
            16'he04b, 16'he050, 16'he048, 16'h0045, 16'he035, 16'h0037, 16'h004a, 16'h004e,
            16'he01c, 16'h004f, 16'h0050, 16'h0051, 16'h004b, 16'h004c, 16'h004d, 16'h0047,
            16'h0048, 16'h0049, 16'h0052, 16'h0053, 16'h0000
        };
    endfunction

    function logic [15:0] set1_code(logic [7:0] usage);
        if (usage >= TABLE_LEN) begin
            return 16'h0000;
        end
        return set1_codes[usage];
    endfunction

    // Queue the make/break beats caused by one accepted report and advance the key state.
    function void add_report(t_in r);
        logic [7:0]  slot [KEY_SLOTS];
        logic [7:0]  nxt [KEY_SLOTS];
        t_out        run [2*KEY_SLOTS+1];
        logic [15:0] code;
        int          pos;
        int          n;
        bit          now_shift;
        bit          scanning;
        bit          claimed;
        slot[0] = r.key_0;
        slot[1] = r.key_1;
        slot[2] = r.key_2;
        slot[3] = r.key_3;
        slot[4] = r.key_4;
        slot[5] = r.key_5;
        foreach (nxt[i]) nxt[i] = 8'h00;
        pos      = 0;
        n        = 0;
        scanning = 1'b1;
        // Each held key claims at most one matching slot; the scan ends at the first empty entry.
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (scanning && down_keys[i] == 8'h00) scanning = 1'b0;
            if (scanning) begin
                claimed = 1'b0;
                for (int j = 0; j < KEY_SLOTS; j++) begin
                    if (!claimed && slot[j] == down_keys[i]) begin
                        slot[j] = 8'h00;
                        claimed = 1'b1;
                        if (pos < KEY_SLOTS) begin
                            nxt[pos] = down_keys[i];
                            pos++;
                        end
                    end
                end
            end
        end
        now_shift = (r.modifier_bits & (LSHIFT_BIT | RSHIFT_BIT)) != 8'h00;
        if (now_shift != shift_latched) begin
            run[n].scan_code   = SHIFT_CODE;
            run[n].is_press    = now_shift;
            run[n].last_of_run = 1'b0;
            n++;
            shift_latched = now_shift;
            shift_edges++;
        end
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (slot[i] != 8'h00) begin
                code = set1_code(slot[i]);
                if (code[15:8] != 8'h00) extended_presses++;
                run[n].scan_code   = code;
                run[n].is_press    = 1'b1;
                run[n].last_of_run = 1'b0;
                n++;
                run[n].scan_code   = code;
                run[n].is_press    = 1'b0;
                run[n].last_of_run = 1'b0;
                n++;
                if (pos < KEY_SLOTS) begin
                    nxt[pos] = slot[i];
                    pos++;
                end
            end
        end
        down_keys = nxt;
        if (n > 0) run[n-1].last_of_run = 1'b1;
        if (n > longest_run) longest_run = n;
        for (int k = 0; k < n; k++) pending_events.push_back(run[k]);
        reports++;
    endfunction

    // Compare one accepted output beat with the oldest queued beat.
    function void check_event(t_out got);
        t_out exp;
        if (pending_events.size() == 0) begin
            $error("unexpected beat: scan_code %h is_press %b last_of_run %b",
                   got.scan_code, got.is_press, got.last_of_run);
            errors++;
            return;
        end
        exp = pending_events.pop_front();
        beats_checked++;
        if (got.scan_code !== exp.scan_code) begin
            $error("scan_code: expected %h, actual %h", exp.scan_code, got.scan_code);
            errors++;
        end
        if (got.is_press !== exp.is_press) begin
            $error("is_press: expected %b, actual %b", exp.is_press, got.is_press);
            errors++;
        end
        if (got.last_of_run !== exp.last_of_run) begin
            $error("last_of_run: expected %b, actual %b", exp.last_of_run, got.last_of_run);
            errors++;
        end
    endfunction

    function int outstanding();
        return pending_events.size();
    endfunction
endclass

module usb_boot_keyboard_to_ps2_tb;

    // Worst case is far below this: about 210 reports, each with 13 beats behind long stalls.
    localparam int CYCLE_LIMIT = 400000;
    // Cycles to keep watching for stray beats once the queue is empty.
    localparam int DRAIN_CYCLES = 40;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_in  in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_data;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int cycle_count = 0;

    // Generator memory: what the previous random report held, so new ones can build on it.
    logic [7:0] last_keys [KEY_SLOTS];
    logic [7:0] last_mods;

    ps2_event_scoreboard sb;

    usb_boot_keyboard_to_ps2 u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Bound the run; a hung handshake ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still queued",
                     cycle_count, sb.outstanding());
            $display("usb_boot_keyboard_to_ps2 verification failed");
            $finish;
        end
    end

    // Output side: check each accepted beat, then pick the stall for the next edge.
    // Values sampled here are the ones from before this edge, since all drives use <=.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            sb.check_event(out_data);
        end
        out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    function automatic t_in make_report(logic [7:0] mods, logic [7:0] k0, logic [7:0] k1,
                                        logic [7:0] k2, logic [7:0] k3, logic [7:0] k4,
                                        logic [7:0] k5);
        t_in r;
        r.modifier_bits = mods;
        r.key_0 = k0;
        r.key_1 = k1;
        r.key_2 = k2;
        r.key_3 = k3;
        r.key_4 = k4;
        r.key_5 = k5;
        return r;
    endfunction

    // Mostly typing-like reports: keep most keys held, add a couple, toggle shift now and
    // then. A share of pure noise, holes, duplicates and out-of-table usages stirs it up.
    function automatic t_in random_report();
        logic [7:0] k [KEY_SLOTS];
        logic [7:0] tmp;
        logic [7:0] mods;
        int         n;
        int         mode;
        int         keep_pct;
        int         a;
        int         b;
        mode = $urandom_range(99);
        n    = 0;
        foreach (k[i]) k[i] = 8'h00;
        if (mode < 15) begin
            mods = 8'($urandom);
            foreach (k[i]) k[i] = 8'($urandom);
        end else begin
            // Release everything now and then so the held list drains.
            keep_pct = (mode < 25) ? 0 : 70;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                if (last_keys[i] != 8'h00 && $urandom_range(99) < keep_pct) begin
                    k[n] = last_keys[i];
                    n++;
                end
            end
            repeat ($urandom_range(2)) begin
                if (n < KEY_SLOTS) begin
                    k[n] = 8'($urandom_range(4, 100));
                    n++;
                end
            end
            if (mode < 40) begin
                a = $urandom_range(KEY_SLOTS - 1);
                case ($urandom_range(3))
                    0: begin
                        k[a] = 8'($urandom);
                    end
                    1: begin
                        k[a] = k[0];
                    end
                    2: begin
                        k[a] = 8'h00;
                    end
                    default: begin
                        k[a] = 8'($urandom_range(101, 255));
                    end
                endcase
            end
            if ($urandom_range(99) < 25) begin
                a    = $urandom_range(KEY_SLOTS - 1);
                b    = $urandom_range(KEY_SLOTS - 1);
                tmp  = k[a];
                k[a] = k[b];
                k[b] = tmp;
            end
            mods = (8'($urandom) & ~(LSHIFT_BIT | RSHIFT_BIT))
                 | (last_mods & (LSHIFT_BIT | RSHIFT_BIT));
            if ($urandom_range(99) < 20) begin
                mods = mods ^ ($urandom_range(1) ? LSHIFT_BIT : RSHIFT_BIT);
            end
        end
        last_keys = k;
        last_mods = mods;
        return make_report(mods, k[0], k[1], k[2], k[3], k[4], k[5]);
    endfunction

    // Present one report and hold it until the input side takes the beat.
    // Valid stays high across back-to-back reports; only the payload moves on.
    task automatic send_report(t_in r);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do begin
            @(posedge i_clk);
        end while (in_stall);
        sb.add_report(r);
    endtask

    task automatic run_random(int count, int idle_pct, int stall_pct);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (count) send_report(random_report());
    endtask

    initial begin
        sb = new();
        foreach (last_keys[i]) last_keys[i] = 8'h00;
        last_mods = 8'h00;

        // Hold reset low at the start, then release it at an edge.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed reports, no idling on either side.
        send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        // Left shift down, then both, then right alone: only the first edge makes a beat.
        send_report(make_report(LSHIFT_BIT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(make_report(LSHIFT_BIT | RSHIFT_BIT, 8'h00, 8'h00, 8'h00, 8'h00,
                                8'h00, 8'h00));
        send_report(make_report(RSHIFT_BIT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        // Control, alt and gui bits set with both shifts up: a shift break and nothing else.
        send_report(make_report(8'hDD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        // Six fresh keys, then the same six held, then two kept in swapped slots.
        send_report(make_report(8'h00, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9));
        send_report(make_report(8'h00, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9));
        send_report(make_report(8'h00, 8'd9, 8'd8, 8'h00, 8'h00, 8'h00, 8'h00));
        // Shift make plus six new keys: the longest possible run.
        send_report(make_report(LSHIFT_BIT, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15));
        // Every bit high: same usage six times, all out of the table.
        send_report(make_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_report(make_report(8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
        // Reserved usages, the last table entry and the first usage past it.
        send_report(make_report(8'h00, 8'd1, 8'd2, 8'd3, 8'd50, 8'd100, 8'd101));
        // Extended codes, including the two-byte pause prefix.
        send_report(make_report(8'h00, 8'd70, 8'd72, 8'd88, 8'd73, 8'd76, 8'd84));
        send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80));
        // Duplicate: one copy is already held, the other counts as a new press.
        send_report(make_report(8'h00, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(make_report(LSHIFT_BIT, 8'h55, 8'hAA, 8'h33, 8'hCC, 8'h0F, 8'hF0));
        send_report(make_report(RSHIFT_BIT | 8'h41, 8'h01, 8'h00, 8'h64, 8'h00, 8'h1E,
                                8'h00));
        send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

        // Random reports: a slow sink first, then a slow source, then full rate.
        run_random(64, 15, 80);
        run_random(64, 80, 15);
        run_random(64, 0, 0);

        // Drop valid, wait for the queue to empty, then watch for stray beats.
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d reports driven, %0d PS/2 beats checked", sb.reports, sb.beats_checked);
        $display("%0d shift edges, %0d extended presses, longest run %0d beats",
                 sb.shift_edges, sb.extended_presses, sb.longest_run);
        if (sb.errors == 0) begin
            $display("usb_boot_keyboard_to_ps2 verification clean");
        end else begin
            $display("usb_boot_keyboard_to_ps2 verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/ubk_pkg.sv
design/ubk_ctrl.sv
design/ubk_dp.sv
design/usb_boot_keyboard_to_ps2.sv
design/ubk_checker.sv
sim/usb_boot_keyboard_to_ps2_tb.sv
